// ===== sv/mfd_pkg.sv =====
package mfd_pkg;

  localparam int FRAME_BYTES = 12;
  localparam int IDX_W = $clog2(FRAME_BYTES);
  localparam int CNT_W = $clog2(FRAME_BYTES + 1);
  localparam int DIGITS = 5;
  localparam int DIGIT_BASE = 5;

  localparam logic [7:0] LEAD_BYTE = 8'h89;
  localparam logic [7:0] END_BYTE = 8'h0A;

  localparam logic [3:0] DIGIT_L = 4'd10;
  localparam logic [3:0] DIGIT_BLANK = 4'd11;
  localparam logic [2:0] POINT_NONE = 3'd4;

  // function selector, byte 1 bits 7..3
  localparam logic [4:0] FN_SEL_GEN       = 5'h14;
  localparam logic [4:0] FN_SEL_FREQ      = 5'h1A;
  localparam logic [4:0] FN_SEL_CAP       = 5'h19;
  localparam logic [4:0] FN_SEL_TEMP      = 5'h18;
  localparam logic [4:0] FN_SEL_DIODE     = 5'h1B;
  localparam logic [4:0] FN_SEL_OHM       = 5'h1C;
  localparam logic [4:0] FN_SEL_AMP       = 5'h15;
  localparam logic [4:0] FN_SEL_MILLIAMP  = 5'h16;
  localparam logic [4:0] FN_SEL_MILLIVOLT = 5'h1D;
  localparam logic [4:0] FN_SEL_VAC       = 5'h1F;
  localparam logic [4:0] FN_SEL_VDC       = 5'h1E;

  // sign field, byte 4 bits 6..4
  localparam logic [2:0] SIGN_FIELD_PLAIN = 3'd0;
  localparam logic [2:0] SIGN_FIELD_POS   = 3'd4;
  localparam logic [2:0] SIGN_FIELD_NEG   = 3'd5;

  typedef enum logic [3:0] {
    FN_GEN, FN_FREQ, FN_CAP, FN_TEMP, FN_DIODE, FN_OHM, FN_AMP, FN_MILLIAMP,
    FN_MILLIVOLT, FN_VAC, FN_VDC, FN_UNKNOWN
  } function_t;

  typedef enum logic [3:0] {
    UNIT_NONE, UNIT_HZ, UNIT_FARAD, UNIT_DEGC, UNIT_VOLT, UNIT_OHM, UNIT_AMP,
    UNIT_MILLIAMP, UNIT_MILLIVOLT, UNIT_UNKNOWN
  } unit_t;

  typedef enum logic [2:0] {
    PRE_NONE, PRE_NANO, PRE_MICRO, PRE_KILO, PRE_MEGA
  } prefix_t;

  typedef enum logic [1:0] {
    SIGN_POS, SIGN_NEG, SIGN_UNKNOWN
  } sign_t;

  typedef struct packed {
    logic [7:0]              fn_byte;
    logic [7:0]              range_byte;
    logic [7:0]              sign_byte;
    logic [DIGITS-1:0][7:0]  digit_bytes;
    logic                    saved;
  } frame_snap_t;

  typedef struct packed {
    function_t              func;
    unit_t                  unit;
    prefix_t                prefix;
    logic [2:0]             point;
    sign_t                  sign;
    logic [DIGITS-1:0][3:0] digits;
    logic                   range_req;
    logic                   saved;
  } result_t;

  typedef struct packed {
    logic       full;
    logic       not_empty;
    logic [1:0] count;
  } queue_status_t;

endpackage

// ===== sv/mfd_front.sv =====
module mfd_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          rx_byte,
  output logic                q_push,
  output mfd_pkg::frame_snap_t q_data
);
  import mfd_pkg::*;

  logic [7:0] frame [FRAME_BYTES];
  logic [7:0] good [FRAME_BYTES];
  logic [7:0] eff [FRAME_BYTES];
  logic [CNT_W-1:0] byte_count;
  logic good_valid;
  logic room;
  logic is_end;
  logic lead_ok;
  logic good_len;

  assign room = byte_count < CNT_W'(FRAME_BYTES);
  assign is_end = rx_byte == END_BYTE;
  assign good_len = byte_count == CNT_W'(FRAME_BYTES - 1);

  always_comb begin
    for (int i = 0; i < FRAME_BYTES; i++) begin
      eff[i] = (room && byte_count[IDX_W-1:0] == IDX_W'(i)) ? rx_byte : frame[i];
    end
  end

  assign lead_ok = eff[0] == LEAD_BYTE;
  assign q_push = accept && is_end && lead_ok;

  always_comb begin
    if (!good_len && good_valid) begin
      q_data.fn_byte = good[1];
      q_data.range_byte = good[2];
      q_data.sign_byte = good[4];
      for (int i = 0; i < DIGITS; i++) q_data.digit_bytes[i] = good[DIGIT_BASE + i];
      q_data.saved = 1'b1;
    end else begin
      q_data.fn_byte = eff[1];
      q_data.range_byte = eff[2];
      q_data.sign_byte = eff[4];
      for (int i = 0; i < DIGITS; i++) q_data.digit_bytes[i] = eff[DIGIT_BASE + i];
      q_data.saved = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      good_valid <= 1'b0;
      for (int i = 0; i < FRAME_BYTES; i++) frame[i] <= '0;
    end else if (accept) begin
      if (room) begin
        frame[byte_count[IDX_W-1:0]] <= rx_byte;
      end
      if (is_end) begin
        byte_count <= '0;
        if (lead_ok && good_len) good_valid <= 1'b1;
      end else if (room) begin
        byte_count <= byte_count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_end && lead_ok && good_len) begin
      for (int i = 0; i < FRAME_BYTES; i++) good[i] <= eff[i];
    end
  end

endmodule

// ===== sv/mfd_queue.sv =====
module mfd_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  mfd_pkg::frame_snap_t  push_data,
  input  logic                  pop,
  output mfd_pkg::frame_snap_t  head,
  output mfd_pkg::queue_status_t status
);
  import mfd_pkg::*;

  frame_snap_t mem [2];
  logic wptr;
  logic rptr;
  logic [1:0] count;

  assign head = mem[rptr];
  assign status.count = count;
  assign status.full = count == 2'd2;
  assign status.not_empty = count != 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      count <= '0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= push_data;
  end

endmodule

// ===== sv/mfd_back.sv =====
module mfd_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic                 cfg_data,
  input  logic                 head_valid,
  input  mfd_pkg::frame_snap_t head,
  output logic                 head_pop,
  input  logic                 out_take,
  output logic                 out_valid,
  output mfd_pkg::result_t     result
);
  import mfd_pkg::*;

  logic range_enable;
  result_t dec;
  logic [7:0] pos;
  logic [7:0] rng;
  logic load;

  function automatic logic [3:0] digit_code(input logic [7:0] b);
    logic [3:0] r;
    if (b >= 8'h30 && b <= 8'h39) r = 4'(b - 8'h30);
    else if (b == 8'h3E) r = DIGIT_L;
    else r = DIGIT_BLANK;
    return r;
  endfunction

  always_comb begin
    rng = {5'd0, head.range_byte[5:3]};
    pos = (rng <= 8'd5) ? rng + 8'd1 : 8'd0;
    dec.func = FN_UNKNOWN;
    dec.unit = UNIT_UNKNOWN;
    dec.prefix = PRE_NONE;
    dec.range_req = 1'b0;
    case (head.fn_byte[7:3])
      FN_SEL_GEN: begin dec.func = FN_GEN; dec.unit = UNIT_NONE; end
      FN_SEL_FREQ: begin dec.func = FN_FREQ; dec.unit = UNIT_HZ; end
      FN_SEL_CAP: begin
        dec.func = FN_CAP;
        dec.unit = UNIT_FARAD;
        if (pos < 8'd4) begin
          dec.prefix = PRE_NANO;
          pos = pos - 8'd1;
        end else begin
          dec.prefix = PRE_MICRO;
          pos = pos - 8'd4;
        end
      end
      FN_SEL_TEMP: begin dec.func = FN_TEMP; dec.unit = UNIT_DEGC; end
      FN_SEL_DIODE: begin dec.func = FN_DIODE; dec.unit = UNIT_VOLT; pos = pos - 8'd1; end
      FN_SEL_OHM: begin
        dec.func = FN_OHM;
        dec.unit = UNIT_OHM;
        if (pos == 8'd1) begin
          dec.prefix = PRE_NONE;
          pos = 8'd2;
        end else if (pos == 8'd5 || pos == 8'd6) begin
          dec.prefix = PRE_MEGA;
          pos = pos - 8'd5;
        end else begin
          dec.prefix = PRE_KILO;
          pos = pos - 8'd2;
        end
      end
      FN_SEL_AMP: begin dec.func = FN_AMP; dec.unit = UNIT_AMP; pos = pos - 8'd1; end
      FN_SEL_MILLIAMP: begin dec.func = FN_MILLIAMP; dec.unit = UNIT_MILLIAMP; end
      FN_SEL_MILLIVOLT: begin dec.func = FN_MILLIVOLT; dec.unit = UNIT_MILLIVOLT; end
      FN_SEL_VAC: begin dec.func = FN_VAC; dec.unit = UNIT_VOLT; pos = pos - 8'd1; end
      FN_SEL_VDC: begin
        dec.func = FN_VDC;
        dec.unit = UNIT_VOLT;
        pos = pos - 8'd1;
        dec.range_req = range_enable && head.range_byte[6];
      end
      default: begin
        dec.func = FN_UNKNOWN;
      end
    endcase
    dec.point = (pos < 8'd4) ? pos[2:0] : POINT_NONE;
    case (head.sign_byte[6:4])
      SIGN_FIELD_PLAIN, SIGN_FIELD_POS: dec.sign = SIGN_POS;
      SIGN_FIELD_NEG: dec.sign = SIGN_NEG;
      default: dec.sign = SIGN_UNKNOWN;
    endcase
    for (int i = 0; i < DIGITS; i++) dec.digits[i] = digit_code(head.digit_bytes[i]);
    dec.saved = head.saved;
  end

  assign load = head_valid && (!out_valid || out_take);
  assign head_pop = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_enable <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write) range_enable <= cfg_data;
      if (load) out_valid <= 1'b1;
      else if (out_take) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) result <= dec;
  end

endmodule

// ===== sv/meter_frame_decoder.sv =====
// Meter frame decoder.
// Input queue side: drive rx_byte with push while full is low; each such
// edge accepts one item, one byte of the meter link. Byte 0x0A ends a frame.
// Result queue side: while empty is low the decoded frame is on the result
// ports; raise pop to take it. Only a frame whose first byte is 0x89 gives
// a result; a frame of the wrong length decodes the last good frame if any.
// The register is written with range_control_write/range_control_data.
// The frame snapshot enters the queue at the edge that accepts its end byte;
// the decode is registered from the queue head once the output is free.
// Throughput: one byte per cycle unless full; the front and the decoder are
// split by a two-entry frame queue, and full rises only when that queue is full.
// If the receiver stalls, one result sits in the output register and two
// more in the queue before full is raised; bytes are never lost.
// Reset (synchronous rst) clears the frame buffer, byte count, saved-frame
// flag, queues and the register; empty is high afterwards.
module meter_frame_decoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] rx_byte,
  input  logic       range_control_write,
  input  logic       range_control_data,
  output logic       empty,
  input  logic       pop,
  output logic [3:0] function_code,
  output logic [3:0] unit_code,
  output logic [2:0] prefix_code,
  output logic [2:0] point_position,
  output logic [1:0] sign_code,
  output logic [3:0] digit_first,
  output logic [3:0] digit_second,
  output logic [3:0] digit_third,
  output logic [3:0] digit_fourth,
  output logic [3:0] digit_fifth,
  output logic       range_step_request,
  output logic       used_saved_frame
);
  import mfd_pkg::*;

  logic accept;
  logic q_push;
  logic q_pop;
  frame_snap_t q_in;
  frame_snap_t q_head;
  queue_status_t q_status;
  logic out_valid;
  result_t result;

  assign accept = push && !full;
  assign full = q_status.full;

  mfd_front u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .rx_byte (rx_byte),
    .q_push  (q_push),
    .q_data  (q_in)
  );

  mfd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .status    (q_status)
  );

  mfd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (range_control_write),
    .cfg_data   (range_control_data),
    .head_valid (q_status.not_empty),
    .head       (q_head),
    .head_pop   (q_pop),
    .out_take   (pop),
    .out_valid  (out_valid),
    .result     (result)
  );

  assign empty = !out_valid;
  assign function_code = result.func;
  assign unit_code = result.unit;
  assign prefix_code = result.prefix;
  assign point_position = result.point;
  assign sign_code = result.sign;
  assign digit_first = result.digits[0];
  assign digit_second = result.digits[1];
  assign digit_third = result.digits[2];
  assign digit_fourth = result.digits[3];
  assign digit_fifth = result.digits[4];
  assign range_step_request = result.range_req;
  assign used_saved_frame = result.saved;

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(q_push && q_status.full))
    else $error("frame queue written while full");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    q_status.count <= 2'd2)
    else $error("frame queue count out of range");

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result pending after reset");

  a_decoded_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (function_code <= FN_UNKNOWN && point_position <= POINT_NONE &&
                sign_code <= SIGN_UNKNOWN))
    else $error("decoded field out of range");

  a_req_vdc: assert property (@(posedge clk) disable iff (rst)
    (!empty && range_step_request) |-> function_code == FN_VDC)
    else $error("range step request outside VDC");

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import mfd_pkg::*;

  localparam logic [7:0] SEL_GEN       = 8'hA0;
  localparam logic [7:0] SEL_FREQ      = 8'hD0;
  localparam logic [7:0] SEL_CAP       = 8'hC8;
  localparam logic [7:0] SEL_TEMP      = 8'hC0;
  localparam logic [7:0] SEL_DIODE     = 8'hD8;
  localparam logic [7:0] SEL_OHM       = 8'hE0;
  localparam logic [7:0] SEL_AMP       = 8'hA8;
  localparam logic [7:0] SEL_MILLIAMP  = 8'hB0;
  localparam logic [7:0] SEL_MILLIVOLT = 8'hE8;
  localparam logic [7:0] SEL_VAC       = 8'hF8;
  localparam logic [7:0] SEL_VDC       = 8'hF0;

  localparam logic [2:0] SIGN_BITS_PLAIN = 3'b000;
  localparam logic [2:0] SIGN_BITS_POS   = 3'b100;
  localparam logic [2:0] SIGN_BITS_NEG   = 3'b101;

  localparam logic [7:0] DIGIT_ZERO_BYTE  = 8'h30;
  localparam logic [7:0] DIGIT_NINE_BYTE  = 8'h39;
  localparam logic [7:0] DIGIT_L_BYTE     = 8'h3E;
  localparam logic [7:0] DIGIT_BLANK_BYTE = 8'h3F;

  localparam logic [2:0] RANGE_CODE_MAX = 3'd5;
  localparam int AUTORANGE_BIT = 6;

  localparam int SETTLE_CYCLES  = 8;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASE_BYTES    = 330;

  typedef struct packed {
    function_t        func;
    unit_t            meas_unit;
    prefix_t          prefix;
    logic [2:0]       point;
    sign_t            sign;
    logic [4:0][3:0]  digits;
    logic             range_req;
    logic             saved;
  } reading_t;

  typedef enum {RX_STEADY, RX_BUSY, RX_SLOW, RX_STALLED} rx_mode_t;

  logic       clk;
  logic       rst;
  logic       push;
  logic       full;
  logic [7:0] rx_byte;
  logic       range_control_write;
  logic       range_control_data;
  logic       empty;
  logic       pop;
  logic [3:0] function_code;
  logic [3:0] unit_code;
  logic [2:0] prefix_code;
  logic [2:0] point_position;
  logic [1:0] sign_code;
  logic [3:0] digit_first;
  logic [3:0] digit_second;
  logic [3:0] digit_third;
  logic [3:0] digit_fourth;
  logic [3:0] digit_fifth;
  logic       range_step_request;
  logic       used_saved_frame;

  meter_frame_decoder uut (
    .clk                (clk),
    .rst                (rst),
    .push               (push),
    .full               (full),
    .rx_byte            (rx_byte),
    .range_control_write(range_control_write),
    .range_control_data (range_control_data),
    .empty              (empty),
    .pop                (pop),
    .function_code      (function_code),
    .unit_code          (unit_code),
    .prefix_code        (prefix_code),
    .point_position     (point_position),
    .sign_code          (sign_code),
    .digit_first        (digit_first),
    .digit_second       (digit_second),
    .digit_third        (digit_third),
    .digit_fourth       (digit_fourth),
    .digit_fifth        (digit_fifth),
    .range_step_request (range_step_request),
    .used_saved_frame   (used_saved_frame)
  );

  // frame model
  logic [7:0] frame_buf [FRAME_BYTES];
  logic [7:0] good_buf [FRAME_BYTES];
  logic [3:0] fill;
  logic       good_seen;
  logic       range_ctl;

  reading_t   readings_due [$];
  logic [7:0] pending [$];
  int         errors;
  int         sent_bytes;
  int         burst_left;
  int         quiet;
  logic       hold_req;
  rx_mode_t   rx_mode;
  int         rx_left;
  reading_t   want;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic reading_t decode_frame(input logic saved);
    reading_t   r;
    logic [2:0] code;
    logic [7:0] pos;
    logic [7:0] b;
    code = frame_buf[2][5:3];
    pos = (code <= RANGE_CODE_MAX) ? {5'd0, code} + 8'd1 : 8'd0;
    r.func = FN_UNKNOWN;
    r.meas_unit = UNIT_UNKNOWN;
    r.prefix = PRE_NONE;
    r.range_req = 1'b0;
    r.saved = saved;
    case ({frame_buf[1][7:3], 3'b000})
      SEL_GEN: begin
        r.func = FN_GEN; r.meas_unit = UNIT_NONE;
      end
      SEL_FREQ: begin
        r.func = FN_FREQ; r.meas_unit = UNIT_HZ;
      end
      SEL_CAP: begin
        r.func = FN_CAP; r.meas_unit = UNIT_FARAD;
        if (pos < 8'd4) begin
          r.prefix = PRE_NANO; pos = pos - 8'd1;
        end else begin
          r.prefix = PRE_MICRO; pos = pos - 8'd4;
        end
      end
      SEL_TEMP: begin
        r.func = FN_TEMP; r.meas_unit = UNIT_DEGC;
      end
      SEL_DIODE: begin
        r.func = FN_DIODE; r.meas_unit = UNIT_VOLT; pos = pos - 8'd1;
      end
      SEL_OHM: begin
        r.func = FN_OHM; r.meas_unit = UNIT_OHM;
        if (pos == 8'd1) begin
          r.prefix = PRE_NONE; pos = 8'd2;
        end else if (pos == 8'd5 || pos == 8'd6) begin
          r.prefix = PRE_MEGA; pos = pos - 8'd5;
        end else begin
          r.prefix = PRE_KILO; pos = pos - 8'd2;
        end
      end
      SEL_AMP: begin
        r.func = FN_AMP; r.meas_unit = UNIT_AMP; pos = pos - 8'd1;
      end
      SEL_MILLIAMP: begin
        r.func = FN_MILLIAMP; r.meas_unit = UNIT_MILLIAMP;
      end
      SEL_MILLIVOLT: begin
        r.func = FN_MILLIVOLT; r.meas_unit = UNIT_MILLIVOLT;
      end
      SEL_VAC: begin
        r.func = FN_VAC; r.meas_unit = UNIT_VOLT; pos = pos - 8'd1;
      end
      SEL_VDC: begin
        r.func = FN_VDC; r.meas_unit = UNIT_VOLT; pos = pos - 8'd1;
        r.range_req = range_ctl & frame_buf[2][AUTORANGE_BIT];
      end
      default: ;
    endcase
    r.point = (pos < 8'd4) ? pos[2:0] : POINT_NONE;
    case (frame_buf[4][6:4])
      SIGN_BITS_PLAIN, SIGN_BITS_POS: r.sign = SIGN_POS;
      SIGN_BITS_NEG: r.sign = SIGN_NEG;
      default: r.sign = SIGN_UNKNOWN;
    endcase
    for (int i = 0; i < 5; i++) begin
      b = frame_buf[DIGIT_BASE + i];
      if (b >= DIGIT_ZERO_BYTE && b <= DIGIT_NINE_BYTE) r.digits[i] = b[3:0];
      else if (b == DIGIT_L_BYTE) r.digits[i] = DIGIT_L;
      else r.digits[i] = DIGIT_BLANK;
    end
    return r;
  endfunction

  task automatic absorb_byte(input logic [7:0] b);
    logic [3:0] prior;
    prior = fill;
    if (fill < FRAME_BYTES) begin
      frame_buf[fill] = b;
      fill = fill + 4'd1;
    end
    if (b != END_BYTE) return;
    fill = 4'd0;
    if (frame_buf[0] != LEAD_BYTE) return;
    if (prior == FRAME_BYTES - 1) begin
      good_buf = frame_buf;
      good_seen = 1'b1;
      readings_due.push_back(decode_frame(1'b0));
    end else if (good_seen) begin
      frame_buf = good_buf;
      readings_due.push_back(decode_frame(1'b1));
    end else begin
      readings_due.push_back(decode_frame(1'b0));
    end
  endtask

  // any byte but the frame end
  function automatic logic [7:0] filler();
    logic [7:0] r;
    r = 8'($urandom);
    if (r == END_BYTE) r = ~r;
    return r;
  endfunction

  // called at a falling edge; returns at a falling edge
  task automatic send_byte(input logic [7:0] b);
    push <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (full) @(posedge clk);
    absorb_byte(b);
    sent_bytes++;
    @(negedge clk);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 40);
    end
  endtask

  task automatic send_pending();
    foreach (pending[i]) send_byte(pending[i]);
    pending.delete();
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (readings_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_range_control(input logic v);
    wait_drained();
    range_control_write <= 1'b1;
    range_control_data <= v;
    @(posedge clk);
    range_ctl = v;
    @(negedge clk);
    range_control_write <= 1'b0;
  endtask

  task automatic build_reading_frame();
    logic [7:0] fn_sel [11];
    logic [7:0] b;
    int         pick;
    fn_sel = '{SEL_GEN, SEL_FREQ, SEL_CAP, SEL_TEMP, SEL_DIODE, SEL_OHM, SEL_AMP,
               SEL_MILLIAMP, SEL_MILLIVOLT, SEL_VAC, SEL_VDC};
    pending.delete();
    pending.push_back(LEAD_BYTE);
    pick = $urandom_range(0, 11);
    b = filler();
    if (pick < 11) b = {fn_sel[pick][7:3], b[2:0]};
    pending.push_back(b);
    pending.push_back(filler());
    pending.push_back(filler());
    b = filler();
    case ($urandom_range(0, 3))
      0: b[6:4] = SIGN_BITS_PLAIN;
      1: b[6:4] = SIGN_BITS_POS;
      2: b[6:4] = SIGN_BITS_NEG;
      default: ;
    endcase
    if (b == END_BYTE) b[7] = 1'b1;
    pending.push_back(b);
    repeat (5) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) b = DIGIT_ZERO_BYTE + 8'($urandom_range(0, 9));
      else if (pick == 7) b = DIGIT_L_BYTE;
      else if (pick == 8) b = DIGIT_BLANK_BYTE;
      else b = filler();
      pending.push_back(b);
    end
    pending.push_back(filler());
    pending.push_back(END_BYTE);
  endtask

  task automatic compare_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s expected %0d actual %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (readings_due.size() == 0) begin
        $error("result with no frame pending");
        errors++;
      end else begin
        want = readings_due.pop_front();
        compare_field("function_code", 8'(want.func), 8'(function_code));
        compare_field("unit_code", 8'(want.meas_unit), 8'(unit_code));
        compare_field("prefix_code", 8'(want.prefix), 8'(prefix_code));
        compare_field("point_position", 8'(want.point), 8'(point_position));
        compare_field("sign_code", 8'(want.sign), 8'(sign_code));
        compare_field("digit_first", 8'(want.digits[0]), 8'(digit_first));
        compare_field("digit_second", 8'(want.digits[1]), 8'(digit_second));
        compare_field("digit_third", 8'(want.digits[2]), 8'(digit_third));
        compare_field("digit_fourth", 8'(want.digits[3]), 8'(digit_fourth));
        compare_field("digit_fifth", 8'(want.digits[4]), 8'(digit_fifth));
        compare_field("range_step_request", 8'(want.range_req), 8'(range_step_request));
        compare_field("used_saved_frame", 8'(want.saved), 8'(used_saved_frame));
      end
    end
  end

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result side
  initial begin
    pop = 1'b0;
    rx_left = 0;
    rx_mode = RX_STEADY;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      if (rx_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_left = $urandom_range(4, 60);
      end
      rx_left--;
      case (rx_mode)
        RX_STEADY: pop <= 1'b1;
        RX_BUSY:   pop <= ($urandom_range(0, 99) < 60);
        RX_SLOW:   pop <= ($urandom_range(0, 4) == 0);
        default:   pop <= 1'b0;
      endcase
    end
  end

  task automatic test_short_frame_unsaved();
    pending = '{LEAD_BYTE, END_BYTE};
    send_pending();
  endtask

  task automatic test_foreign_lead();
    pending = '{END_BYTE, 8'hFF, END_BYTE};
    send_pending();
  endtask

  task automatic test_autorange_request();
    pending = '{LEAD_BYTE, SEL_VDC, 8'h40, 8'h00, 8'h50, DIGIT_ZERO_BYTE,
                DIGIT_NINE_BYTE, DIGIT_L_BYTE, DIGIT_BLANK_BYTE, 8'hFF, 8'h00, END_BYTE};
    send_pending();
  endtask

  // too long: last good frame decoded instead
  task automatic test_overflow_saved();
    pending.push_back(LEAD_BYTE);
    repeat (6) begin
      pending.push_back(8'hFF);
      pending.push_back(8'h00);
    end
    pending.push_back(END_BYTE);
    send_pending();
  endtask

  task automatic test_random_traffic(input int n_bytes);
    int start;
    int pick;
    start = sent_bytes;
    while (sent_bytes - start < n_bytes) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        build_reading_frame();
      end else if (pick == 7) begin
        pending.push_back(($urandom_range(0, 4) != 0) ? LEAD_BYTE : filler());
        repeat ($urandom_range(0, 9)) pending.push_back(filler());
        pending.push_back(END_BYTE);
      end else if (pick == 8) begin
        pending.push_back(LEAD_BYTE);
        repeat ($urandom_range(11, 16)) pending.push_back(filler());
        pending.push_back(END_BYTE);
      end else begin
        repeat ($urandom_range(1, 8))
          pending.push_back(($urandom_range(0, 3) == 0) ? END_BYTE : 8'($urandom));
      end
      send_pending();
    end
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    repeat (6) begin
      build_reading_frame();
      send_pending();
    end
    wait_drained();
  endtask

  initial begin
    rst = 1'b1;
    push = 1'b0;
    rx_byte = 8'h00;
    range_control_write = 1'b0;
    range_control_data = 1'b0;
    foreach (frame_buf[i]) frame_buf[i] = 8'h00;
    fill = 4'd0;
    good_seen = 1'b0;
    range_ctl = 1'b0;
    errors = 0;
    sent_bytes = 0;
    burst_left = 1;
    quiet = 0;
    hold_req = 1'b0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_short_frame_unsaved();
    test_foreign_lead();
    set_range_control(1'b1);
    test_autorange_request();
    test_overflow_saved();
    set_range_control(1'b0);
    test_random_traffic(PHASE_BYTES);
    set_range_control(1'b1);
    test_random_traffic(PHASE_BYTES);
    test_backpressure();
    set_range_control(1'b0);
    test_random_traffic(PHASE_BYTES);
    set_range_control(1'b1);
    test_random_traffic(PHASE_BYTES);

    wait_drained();
    repeat (20) @(negedge clk);
    if (errors == 0 && readings_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/mfd_pkg.sv
sv/mfd_front.sv
sv/mfd_queue.sv
sv/mfd_back.sv
sv/meter_frame_decoder.sv
test/testbench.sv
